FILE: sv/thtmp_pkg.sv
// ----------------------------------------------------------------------------
// thtmp_pkg
// shared constants, calibration table and handshake structs for the
// thermistor sample to temperature converter
// ----------------------------------------------------------------------------
package thtmp_pkg;

  // sample and table geometry
  localparam int SAMPLE_BITS   = 12;
  localparam int TABLE_ENTRIES = 31;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int LAST_IDX      = TABLE_ENTRIES - 1;
  localparam int HINT_RESET    = 6;

  // temperature grid in tenths of a degree
  localparam int TEMP_BASE = -200;
  localparam int TEMP_STEP = 40;
  localparam int TEMP_TOP  = TEMP_BASE + TEMP_STEP * LAST_IDX;
  localparam int TEMP_W    = 16;
  localparam int T_W       = 12;  // two's complement working width of t
  localparam int MAG_W     = 10;  // magnitude of t, at most 1000

  // interpolation divide: quotient stays below TEMP_STEP
  localparam int QUOT_W = $clog2(TEMP_STEP);
  localparam int CNT_W  = $clog2(QUOT_W);
  localparam int NUM_W  = SAMPLE_BITS + QUOT_W;

  // 90/100 reduces to 9/10; /10 done as a reciprocal multiply
  localparam int SCALE_NUM   = 9;
  localparam int PROD_W      = 14;  // 9 * 1000 fits
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;
  localparam int DIV10_W     = PROD_W + 16;

  // strictly decreasing calibration points, entry k at -20.0 + 4.0*k degrees
  localparam logic [SAMPLE_BITS-1:0] CAL_TABLE [TABLE_ENTRIES] = '{
    12'd2890, 12'd2817, 12'd2735, 12'd2642, 12'd2541, 12'd2431, 12'd2318,
    12'd2202, 12'd2127, 12'd2007, 12'd1846, 12'd1687, 12'd1546, 12'd1422,
    12'd1309, 12'd1202, 12'd1099, 12'd1001, 12'd907,  12'd817,  12'd727,
    12'd677,  12'd613,  12'd550,  12'd496,  12'd452,  12'd414,  12'd379,
    12'd345,  12'd311,  12'd277
  };

  typedef struct packed {
    logic                   start;
    logic [NUM_W-1:0]       dividend;
    logic [SAMPLE_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/thtmp_stream_if.sv
// ----------------------------------------------------------------------------
// thtmp stream interfaces
// valid/ready channels for converter samples and temperature words
// ----------------------------------------------------------------------------
interface thtmp_sample_if import thtmp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface thtmp_temp_if import thtmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] temp_word;

  modport source (output valid, output temp_word, input ready);
  modport sink   (input valid, input temp_word, output ready);
endinterface

FILE: sv/thtmp_cal_rom.sv
// ----------------------------------------------------------------------------
// thtmp_cal_rom
// calibration table with two synchronous read ports
// ----------------------------------------------------------------------------
module thtmp_cal_rom import thtmp_pkg::*; (
  input  logic                   clk_i,
  input  logic [IDX_W-1:0]       addr_lo_i,
  input  logic [IDX_W-1:0]       addr_hi_i,
  output logic [SAMPLE_BITS-1:0] data_lo_o,
  output logic [SAMPLE_BITS-1:0] data_hi_o
);

  logic [SAMPLE_BITS-1:0] data_lo_q;
  logic [SAMPLE_BITS-1:0] data_hi_q;

  // unused top code reads as zero
  always_ff @(posedge clk_i) begin
    data_lo_q <= (int'(addr_lo_i) <= LAST_IDX) ? CAL_TABLE[addr_lo_i] : '0;
    data_hi_q <= (int'(addr_hi_i) <= LAST_IDX) ? CAL_TABLE[addr_hi_i] : '0;
  end

  assign data_lo_o = data_lo_q;
  assign data_hi_o = data_hi_q;

endmodule

FILE: sv/thtmp_divider.sv
// ----------------------------------------------------------------------------
// thtmp_divider
// restoring divider, one quotient bit per cycle, for the interpolation fraction
// ----------------------------------------------------------------------------
module thtmp_divider import thtmp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                   busy_q;
  logic                   done_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [NUM_W-1:0]       rem_q;
  logic [SAMPLE_BITS-1:0] dsr_q;
  logic [QUOT_W-1:0]      quot_q;
  logic [NUM_W-1:0]       trial;
  logic                   fits;

  assign trial = NUM_W'(dsr_q) << cnt_q;
  assign fits  = rem_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.dividend;
      dsr_q  <= req_i.divisor;
      cnt_q  <= CNT_W'(QUOT_W - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - trial;
      end
      quot_q[cnt_q] <= fits;
      cnt_q         <= cnt_q - CNT_W'(1);
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule

FILE: sv/thermistor_adc_to_temperature.sv
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// thermistor sample to sign-magnitude temperature by table interpolation
// ----------------------------------------------------------------------------
// One request carries a 12-bit thermistor reading; one result word comes back
// for every request. The reading is placed in a segment of a 31-point
// decreasing calibration table (points 4.0 degrees apart from -20.0), the
// temperature is interpolated in tenths of a degree, scaled by 0.9 with
// truncation, and returned as bit 15 sign plus bits 14:0 magnitude. Readings
// at or above the first point give -180 tenths, readings under the last give
// 900. The segment search starts from the segment used by the previous
// request and walks one segment at a time. Each probe is a synchronous table
// read in ST_FETCH followed by a compare in ST_CMP. The fraction comes from a
// one-bit-per-cycle divider, and the sign and scaling are registered in
// ST_SCALE before the word waits in ST_DONE for the output register.
// One request is worked on at a time; a finished word sits in an output
// register, so a new request is taken while the previous result still waits
// for its sink.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature import thtmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  thtmp_sample_if.sink   sample_i,
  thtmp_temp_if.source   temp_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_DIV,
    ST_SCALE,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [SAMPLE_BITS-1:0] x_q;
  logic [IDX_W-1:0]       k_q;
  logic [IDX_W-1:0]       hint_q;
  logic [T_W-1:0]         t_q;
  logic                   neg_q;
  logic [PROD_W-1:0]      prod_q;
  logic                   out_valid_q;
  logic [TEMP_W-1:0]      out_word_q;
  div_req_t               div_req_q;
  div_rsp_t               div_rsp;

  logic [SAMPLE_BITS-1:0] rom_lo;
  logic [SAMPLE_BITS-1:0] rom_hi;
  logic [IDX_W-1:0]       hint_clamped;
  logic [SAMPLE_BITS-1:0] span;
  logic [SAMPLE_BITS-1:0] offs;
  logic [T_W-1:0]         t_node;   // temperature at table point k
  logic [T_W-1:0]         t_mag;
  logic [DIV10_W-1:0]     div10;
  logic                   out_free;
  logic                   seg_hit;
  logic                   div_go;
  logic                   out_load;

  // table: lower bound at k, upper bound at k-1
  thtmp_cal_rom u_rom (
    .clk_i     (clk_i),
    .addr_lo_i (k_q),
    .addr_hi_i (k_q - IDX_W'(1)),
    .data_lo_o (rom_lo),
    .data_hi_o (rom_hi)
  );

  thtmp_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // hint always stays in range, clamp kept for safety
  always_comb begin
    if (hint_q < IDX_W'(1)) begin
      hint_clamped = IDX_W'(1);
    end else if (hint_q > IDX_W'(LAST_IDX)) begin
      hint_clamped = IDX_W'(LAST_IDX);
    end else begin
      hint_clamped = hint_q;
    end
  end

  assign span   = rom_hi - rom_lo;
  assign offs   = x_q - rom_lo;
  // two's complement wrap in T_W bits gives the signed value
  assign t_node = T_W'(k_q) * T_W'(TEMP_STEP) + T_W'(TEMP_BASE);
  assign t_mag  = t_q[T_W-1] ? (T_W'(0) - t_q) : t_q;
  // divide by ten through the reciprocal, exact for the product range
  assign div10  = (DIV10_W'(prod_q) * DIV10_W'(DIV10_MUL)) >> DIV10_SHIFT;

  assign out_free = !out_valid_q || temp_o.ready;

  // reading inside segment k, and a fraction to work out
  assign seg_hit  = (x_q >= rom_lo) && (x_q < rom_hi);
  assign div_go   = (state_q == ST_CMP) && seg_hit && (span != '0);
  assign out_load = (state_q == ST_DONE) && out_free;

  assign sample_i.ready  = (state_q == ST_IDLE);
  assign temp_o.valid    = out_valid_q;
  assign temp_o.temp_word = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      k_q         <= IDX_W'(HINT_RESET);
      hint_q      <= IDX_W'(HINT_RESET);
      t_q         <= '0;
      neg_q       <= 1'b0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      div_req_q   <= '0;
    end else begin
      div_req_q.start <= div_go;
      // new word loaded, or result taken by the sink
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (temp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (sample_i.valid) begin
            x_q     <= sample_i.adc_sample;
            k_q     <= hint_clamped;
            state_q <= ST_FETCH;
          end
        end

        // table read for segment k in flight
        ST_FETCH: begin
          state_q <= ST_CMP;
        end

        ST_CMP: begin
          priority if (x_q < rom_lo) begin
            // hotter side of the table: walk up
            if (k_q == IDX_W'(LAST_IDX)) begin
              t_q     <= T_W'(TEMP_TOP);
              hint_q  <= k_q;
              state_q <= ST_SCALE;
            end else begin
              k_q     <= k_q + IDX_W'(1);
              state_q <= ST_FETCH;
            end
          end else if (x_q >= rom_hi) begin
            // colder side: walk down
            if (k_q == IDX_W'(1)) begin
              t_q     <= T_W'(TEMP_BASE);
              hint_q  <= k_q;
              state_q <= ST_SCALE;
            end else begin
              k_q     <= k_q - IDX_W'(1);
              state_q <= ST_FETCH;
            end
          end else begin
            hint_q <= k_q;
            if (span == '0) begin
              // flat segment, no fraction
              t_q     <= t_node;
              state_q <= ST_SCALE;
            end else begin
              div_req_q.dividend <= NUM_W'(offs) * NUM_W'(TEMP_STEP);
              div_req_q.divisor  <= span;
              state_q            <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          if (div_rsp.done) begin
            t_q     <= t_node - T_W'(div_rsp.quotient);
            state_q <= ST_SCALE;
          end
        end

        // sign and times nine
        ST_SCALE: begin
          neg_q   <= t_q[T_W-1];
          prod_q  <= PROD_W'(MAG_W'(t_mag)) * PROD_W'(SCALE_NUM);
          state_q <= ST_DONE;
        end

        // wait for the output register, then hand over
        ST_DONE: begin
          if (out_free) begin
            out_word_q  <= {neg_q, (TEMP_W - 1)'(div10)};
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // segment index stays a valid segment while searching
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (k_q >= IDX_W'(1) && k_q <= IDX_W'(LAST_IDX)))
    else $error("segment index out of range");

  // a compare always sees table data read for the current index
  a_cmp_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ($past(state_q) == ST_FETCH))
    else $error("compare without table read");

  // fraction never reaches one full step
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (div_rsp.quotient < QUOT_W'(TEMP_STEP)))
    else $error("interpolation fraction too large");

  // negative results never exceed 180 tenths after scaling
  a_neg_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (temp_o.valid && temp_o.temp_word[TEMP_W-1])
      |-> (temp_o.temp_word[TEMP_W-2:0] <= (TEMP_W - 1)'(180)))
    else $error("negative magnitude out of range");
`endif

endmodule
